@@ design/eatrm_pkg.sv @@
// Package for the Euler-angle to rotation-matrix core: widths, CORDIC tables, beat types.
// No dependencies.
`default_nettype none
package eatrm_pkg;
  localparam int ANGLE_BITS = 16;
  localparam int ENTRY_BITS = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = $clog2(CORDIC_STEPS);  // cell step index width
  localparam int WORK_FRAC = 30;
  localparam int TRIG_FRAC = 20;
  localparam int ENTRY_FRAC = ENTRY_BITS - 2;
  localparam int ZW = 34;  // work angle width, covers +-4 rad plus reduction
  localparam int XW = 33;  // cordic x/y width
  localparam int TW = 23;  // Q.20 trig width
  localparam int PW = 46;  // two-factor product width
  localparam int SW = 72;  // Q.60 sum width
  localparam int SH = 3 * TRIG_FRAC - ENTRY_FRAC;
  localparam int NLAT = CORDIC_STEPS + 6;

  localparam logic signed [ZW-1:0] HALF_PI = 34'sd1686629713;
  localparam logic signed [ZW-1:0] QUARTER_PI = 34'sd843314857;
  localparam logic signed [XW-1:0] CORDIC_GAIN = 33'sd652032874;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;
  typedef logic signed [ENTRY_BITS-1:0] entry_t;
  typedef logic signed [TW-1:0] trig_t;

  typedef struct packed {
    angle_t angle_x;
    angle_t angle_y;
    angle_t angle_z;
  } angles_t;

  typedef struct packed {
    entry_t m00; entry_t m01; entry_t m02;
    entry_t m10; entry_t m11; entry_t m12;
    entry_t m20; entry_t m21; entry_t m22;
  } matrix_t;

  // one CORDIC lane: angle residue, vector and quarter-turn count
  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic [1:0] k;
  } lane_t;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    case (i)
      0: return 34'sd843314856;   1: return 34'sd497837829;
      2: return 34'sd263043836;   3: return 34'sd133525158;
      4: return 34'sd67021686;    5: return 34'sd33543515;
      6: return 34'sd16775850;    7: return 34'sd8388437;
      8: return 34'sd4194282;     9: return 34'sd2097149;
      10: return 34'sd1048575;    11: return 34'sd524287;
      12: return 34'sd262143;     13: return 34'sd131071;
      14: return 34'sd65535;      15: return 34'sd32767;
      16: return 34'sd16383;      17: return 34'sd8191;
      18: return 34'sd4095;       19: return 34'sd2047;
      20: return 34'sd1023;       21: return 34'sd511;
      22: return 34'sd255;        default: return 34'sd127;
    endcase
  endfunction
endpackage
`default_nettype wire

@@ design/eatrm_stream_if.sv @@
// Valid/ready stream channel with a generic payload type.
// No dependencies.
`default_nettype none
interface eatrm_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/euler_angles_to_rotation_matrix_core.sv @@
// Top level: Euler xyz angles to rotation matrix Rz*Ry*Rx.
// Depends on eatrm_pkg, eatrm_stream_if, eatrm_cell, eatrm_product.
//
// Usage:
//   in  (sink)  : one beat carries angle_x, angle_y, angle_z, signed Q3.13 rad.
//   out (source): one beat carries m00..m22, signed Q1.14, saturated to +-1.
//   A beat is taken when valid and ready are high at a rising clk edge.
// Datapath: input reduction stage, a row of CORDIC_STEPS cells (one step each,
//   all three angles in parallel), a rounding/quadrant stage, then three
//   product/sum stages and the output register. Throughput one beat per cycle
//   while the receiver keeps out.ready high.
// Flow control: the whole pipe advances when the output register is empty
//   or is being drained, so in.ready = !out.valid || out.ready. A stalled
//   receiver freezes every stage; nothing is dropped.
// Reset (rst, synchronous, active high) clears the valid bits of the pipe
//   only; payload registers are not reset. No state survives between beats.
`default_nettype none
module euler_angles_to_rotation_matrix_core (
  input wire logic clk,
  input wire logic rst,
  eatrm_stream_if.sink in,
  eatrm_stream_if.source out
);
  localparam int N = eatrm_pkg::CORDIC_STEPS;

  logic en;
  logic [eatrm_pkg::NLAT-1:0] vld;

  assign en = !out.valid || out.ready;
  assign in.ready = en;
  assign out.valid = vld[eatrm_pkg::NLAT-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[eatrm_pkg::NLAT-2:0], in.valid};
  end

  // quadrant reduction, registered as the first stage
  function automatic eatrm_pkg::lane_t reduce(input eatrm_pkg::angle_t a);
    eatrm_pkg::lane_t r;
    r.z = eatrm_pkg::ZW'(a) <<< (eatrm_pkg::WORK_FRAC - (eatrm_pkg::ANGLE_BITS - 3));
    r.k = 2'd0;
    for (int i = 0; i < 3; i++)
      if (r.z > eatrm_pkg::QUARTER_PI) begin
        r.z = r.z - eatrm_pkg::HALF_PI; r.k = r.k + 2'd1;
      end
    for (int i = 0; i < 3; i++)
      if (r.z < -eatrm_pkg::QUARTER_PI) begin
        r.z = r.z + eatrm_pkg::HALF_PI; r.k = r.k - 2'd1;
      end
    r.x = eatrm_pkg::CORDIC_GAIN;
    r.y = '0;
    return r;
  endfunction

  eatrm_pkg::lane_t chain [N+1][3];

  always_ff @(posedge clk) begin
    if (en) begin
      chain[0][0] <= reduce(in.data.angle_x);
      chain[0][1] <= reduce(in.data.angle_y);
      chain[0][2] <= reduce(in.data.angle_z);
    end
  end

  // cell g runs CORDIC step g
  for (genvar g = 0; g < N; g++) begin : g_cell
    eatrm_cell u_cell (
      .clk(clk), .en(en), .step(eatrm_pkg::STEP_W'(g)),
      .lane_in(chain[g]), .lane_out(chain[g+1])
    );
  end

  // round to Q.20 and apply quarter turns
  eatrm_pkg::trig_t cs [3];
  eatrm_pkg::trig_t sn [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        logic signed [eatrm_pkg::XW-1:0] cr, sr;
        eatrm_pkg::trig_t c, s;
        cr = (chain[N][l].x + (eatrm_pkg::XW'(1) <<< 9)) >>> 10;
        sr = (chain[N][l].y + (eatrm_pkg::XW'(1) <<< 9)) >>> 10;
        c = eatrm_pkg::trig_t'(cr);
        s = eatrm_pkg::trig_t'(sr);
        case (chain[N][l].k)
          2'd0: begin cs[l] <= c;  sn[l] <= s;  end
          2'd1: begin cs[l] <= -s; sn[l] <= c;  end
          2'd2: begin cs[l] <= -c; sn[l] <= -s; end
          default: begin cs[l] <= s; sn[l] <= -c; end
        endcase
      end
    end
  end

  eatrm_pkg::matrix_t mat;

  eatrm_product u_product (
    .clk(clk), .en(en),
    .cx(cs[0]), .sx(sn[0]), .cy(cs[1]), .sy(sn[1]), .cz(cs[2]), .sz(sn[2]),
    .mat(mat)
  );

  // output register
  always_ff @(posedge clk) begin
    if (en) out.data <= mat;
  end
endmodule
`default_nettype wire

@@ design/eatrm_cell.sv @@
// One CORDIC rotation cell for three lanes; step index comes in on a port.
// Depends on eatrm_pkg.
`default_nettype none
module eatrm_cell (
  input  wire logic clk,
  input  wire logic en,
  input  wire logic [eatrm_pkg::STEP_W-1:0] step,
  input  wire eatrm_pkg::lane_t lane_in [3],
  output eatrm_pkg::lane_t lane_out [3]
);
  eatrm_pkg::lane_t lane_next [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      lane_next[l].k = lane_in[l].k;
      if (!lane_in[l].z[eatrm_pkg::ZW-1]) begin
        lane_next[l].x = lane_in[l].x - (lane_in[l].y >>> step);
        lane_next[l].y = lane_in[l].y + (lane_in[l].x >>> step);
        lane_next[l].z = lane_in[l].z - eatrm_pkg::atan_q30(int'(step));
      end else begin
        lane_next[l].x = lane_in[l].x + (lane_in[l].y >>> step);
        lane_next[l].y = lane_in[l].y - (lane_in[l].x >>> step);
        lane_next[l].z = lane_in[l].z + eatrm_pkg::atan_q30(int'(step));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) lane_out <= lane_next;
  end
endmodule
`default_nettype wire

@@ design/eatrm_product.sv @@
// Closed-form matrix products with rounding and saturation, three register stages.
// Depends on eatrm_pkg.
`default_nettype none
module eatrm_product (
  input  wire logic clk,
  input  wire logic en,
  input  wire eatrm_pkg::trig_t cx, sx, cy, sy, cz, sz,
  output eatrm_pkg::matrix_t mat
);
  typedef logic signed [eatrm_pkg::PW-1:0] prod_t;
  typedef logic signed [eatrm_pkg::SW-1:0] sum_t;

  // stage 1: pair products
  prod_t czcy, szcy, cysx, cycx, czsy, szsy, szcx, szsx, czcx, czsx;
  eatrm_pkg::trig_t sx1, cx1, sy1;
  // stage 2: triple products and lifted pairs
  sum_t t01, t02, t11, t12, p01, p02, p11, p12, p00, p10, p20, p21, p22;
  sum_t e [9];

  function automatic eatrm_pkg::entry_t fin(input sum_t v);
    sum_t r;
    sum_t one;
    r = (v + (sum_t'(1) <<< (eatrm_pkg::SH - 1))) >>> eatrm_pkg::SH;
    one = sum_t'(1) <<< eatrm_pkg::ENTRY_FRAC;
    if (r > one) r = one;
    if (r < -one) r = -one;
    return eatrm_pkg::entry_t'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      czcy <= prod_t'(cz) * prod_t'(cy);
      szcy <= prod_t'(sz) * prod_t'(cy);
      cysx <= prod_t'(cy) * prod_t'(sx);
      cycx <= prod_t'(cy) * prod_t'(cx);
      czsy <= prod_t'(cz) * prod_t'(sy);
      szsy <= prod_t'(sz) * prod_t'(sy);
      szcx <= prod_t'(sz) * prod_t'(cx);
      szsx <= prod_t'(sz) * prod_t'(sx);
      czcx <= prod_t'(cz) * prod_t'(cx);
      czsx <= prod_t'(cz) * prod_t'(sx);
      sx1 <= sx; cx1 <= cx; sy1 <= sy;
      t01 <= sum_t'(czsy) * sum_t'(sx1);
      t02 <= sum_t'(czsy) * sum_t'(cx1);
      t11 <= sum_t'(szsy) * sum_t'(sx1);
      t12 <= sum_t'(szsy) * sum_t'(cx1);
      p01 <= sum_t'(szcx) <<< eatrm_pkg::TRIG_FRAC;
      p02 <= sum_t'(szsx) <<< eatrm_pkg::TRIG_FRAC;
      p11 <= sum_t'(czcx) <<< eatrm_pkg::TRIG_FRAC;
      p12 <= sum_t'(czsx) <<< eatrm_pkg::TRIG_FRAC;
      p00 <= sum_t'(czcy) <<< eatrm_pkg::TRIG_FRAC;
      p10 <= sum_t'(szcy) <<< eatrm_pkg::TRIG_FRAC;
      p20 <= -(sum_t'(sy1) <<< (2 * eatrm_pkg::TRIG_FRAC));
      p21 <= sum_t'(cysx) <<< eatrm_pkg::TRIG_FRAC;
      p22 <= sum_t'(cycx) <<< eatrm_pkg::TRIG_FRAC;
      e[0] <= p00; e[1] <= t01 - p01; e[2] <= t02 + p02;
      e[3] <= p10; e[4] <= t11 + p11; e[5] <= t12 - p12;
      e[6] <= p20; e[7] <= p21;       e[8] <= p22;
    end
  end

  assign mat = '{fin(e[0]), fin(e[1]), fin(e[2]), fin(e[3]), fin(e[4]),
                 fin(e[5]), fin(e[6]), fin(e[7]), fin(e[8])};
endmodule
`default_nettype wire

@@ dv/euler_matrix_checker.sv @@
// Checker for the Euler-angle to rotation-matrix core: predicts each matrix beat
// from the accepted angle beats and compares field by field. Depends on eatrm_pkg.
`default_nettype none
module euler_matrix_checker
  import eatrm_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire angles_t in_data,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire matrix_t out_data,
  output int       fail_count,
  output int       pending_count,
  output int       matrix_count
);
  localparam longint WGAIN = 652032874;
  localparam longint WHALF = 1686629713;
  localparam longint WQUART = 843314857;

  matrix_t expected_matrices[$];

  function automatic longint atan_entry(input int i);
    longint tab[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127};
    return tab[i];
  endfunction

  // cos and sin of one angle, Q.20
  function automatic void sin_cos(input angle_t ang, output longint c_o,
                                  output longint s_o);
    longint z, x, y, dx, dy, c, s;
    int k;
    z = longint'(ang) <<< (WORK_FRAC - (ANGLE_BITS - 3));
    k = 0;
    repeat (3) if (z > WQUART) begin z -= WHALF; k++; end
    repeat (3) if (z < -WQUART) begin z += WHALF; k--; end
    x = WGAIN;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    c = (x + (64'sd1 <<< (WORK_FRAC - TRIG_FRAC - 1))) >>> (WORK_FRAC - TRIG_FRAC);
    s = (y + (64'sd1 <<< (WORK_FRAC - TRIG_FRAC - 1))) >>> (WORK_FRAC - TRIG_FRAC);
    case (k & 3)
      0: begin c_o = c;  s_o = s;  end
      1: begin c_o = -s; s_o = c;  end
      2: begin c_o = -c; s_o = -s; end
      default: begin c_o = s; s_o = -c; end
    endcase
  endfunction

  // Q.60 sum down to a saturated Q1.14 entry
  function automatic entry_t to_entry(input longint v60);
    longint r, one;
    one = 64'sd1 <<< ENTRY_FRAC;
    r = (v60 + (64'sd1 <<< (SH - 1))) >>> SH;
    if (r > one) r = one;
    if (r < -one) r = -one;
    return entry_t'(r);
  endfunction

  function automatic matrix_t rotation_of(input angles_t a);
    longint cx, sx, cy, sy, cz, sz, l;
    matrix_t m;
    l = 64'sd1 <<< TRIG_FRAC;
    sin_cos(a.angle_x, cx, sx);
    sin_cos(a.angle_y, cy, sy);
    sin_cos(a.angle_z, cz, sz);
    m.m00 = to_entry(cz * cy * l);
    m.m01 = to_entry(cz * sy * sx - sz * cx * l);
    m.m02 = to_entry(cz * sy * cx + sz * sx * l);
    m.m10 = to_entry(sz * cy * l);
    m.m11 = to_entry(sz * sy * sx + cz * cx * l);
    m.m12 = to_entry(sz * sy * cx - cz * sx * l);
    m.m20 = to_entry(-(sy * l * l));
    m.m21 = to_entry(cy * sx * l);
    m.m22 = to_entry(cy * cx * l);
    return m;
  endfunction

  task automatic check_entry(input string name, input entry_t exp_v, input entry_t act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    matrix_count = 0;
  end
  assign pending_count = expected_matrices.size();

  always @(posedge clk) begin
    matrix_t e;
    if (!rst) begin
      if (in_valid && in_ready) expected_matrices.push_back(rotation_of(in_data));
      if (out_valid && out_ready) begin
        matrix_count++;
        if (expected_matrices.size() == 0) begin
          $display("%0t: unexpected matrix beat, actual %h", $time, out_data);
          fail_count++;
        end else begin
          e = expected_matrices.pop_front();
          check_entry("m00", e.m00, out_data.m00);
          check_entry("m01", e.m01, out_data.m01);
          check_entry("m02", e.m02, out_data.m02);
          check_entry("m10", e.m10, out_data.m10);
          check_entry("m11", e.m11, out_data.m11);
          check_entry("m12", e.m12, out_data.m12);
          check_entry("m20", e.m20, out_data.m20);
          check_entry("m21", e.m21, out_data.m21);
          check_entry("m22", e.m22, out_data.m22);
        end
      end
    end
  end
endmodule
`default_nettype wire

@@ dv/euler_angles_to_rotation_matrix_core_test.sv @@
// Testbench top for euler_angles_to_rotation_matrix_core: drives angle beats,
// stalls the matrix side, takes the verdict from euler_matrix_checker.
`default_nettype none
module euler_angles_to_rotation_matrix_core_test;
  import eatrm_pkg::*;

  localparam int RANDOM_BEATS = 630;
  localparam int DRAIN_CYCLES = NLAT + 10;

  logic clk;
  logic rst;
  int   fail_count, pending_count, matrix_count;
  int   sent_count;
  bit   hold_off;   // long receiver stall window

  eatrm_stream_if #(angles_t) angle_ch ();
  eatrm_stream_if #(matrix_t) matrix_ch ();

  euler_angles_to_rotation_matrix_core i_dut (
    .clk (clk),
    .rst (rst),
    .in  (angle_ch.sink),
    .out (matrix_ch.source)
  );

  euler_matrix_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (angle_ch.valid),
    .in_ready      (angle_ch.ready),
    .in_data       (angle_ch.data),
    .out_valid     (matrix_ch.valid),
    .out_ready     (matrix_ch.ready),
    .out_data      (matrix_ch.data),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .matrix_count  (matrix_count)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Gap length: mostly zero or short, now and then long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Angle with bias toward quadrant edges and the field extremes.
  function automatic angle_t pick_angle();
    int p;
    angle_t pi_half;
    pi_half = 16'sd12868;  // pi/2 in Q3.13
    p = $urandom_range(99);
    if (p < 60) return angle_t'($urandom_range(65535));
    if (p < 80) return angle_t'(int'(pi_half) * $signed($urandom_range(4)) / 2 * 1 +
                                $signed($urandom_range(8)) - 4);
    if (p < 90) return angle_t'(-int'(pi_half) * $signed($urandom_range(4)) / 2 +
                                $signed($urandom_range(8)) - 4);
    return $urandom_range(1) ? 16'sh7fff - angle_t'($urandom_range(3))
                             : 16'sh8000 + angle_t'($urandom_range(3));
  endfunction

  // One beat offered on the falling edge, held until accepted.
  task automatic send_angles(input angles_t a);
    angle_ch.valid <= 1'b1;
    angle_ch.data  <= a;
    @(posedge clk);
    while (!angle_ch.ready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic idle_input(input int n);
    if (n > 0) begin
      angle_ch.valid <= 1'b0;
      angle_ch.data  <= angles_t'({$urandom, $urandom});
      repeat (n) @(negedge clk);
    end
  endtask

  // Receiver: random ready, plus one long hold-off while the sender keeps going.
  initial begin
    int n;
    matrix_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off) begin
        matrix_ch.ready <= 1'b0;
        repeat (80) @(negedge clk);
        hold_off = 0;
      end
      n = gap_len();
      if (n > 0) begin
        matrix_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      matrix_ch.ready <= 1'b1;
      repeat ($urandom_range(30, 1)) @(negedge clk);
    end
  end

  initial begin
    angles_t a;
    int drain;
    angle_t directed[$];
    sent_count = 0;
    hold_off = 0;
    rst = 1'b1;
    angle_ch.valid = 1'b0;
    angle_ch.data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero, extremes (incl. most negative angle -4.0), right angles,
    // quadrant boundaries at +-pi/4 and near-saturating entries.
    directed = '{16'sd0, 16'sh7fff, 16'sh8000, 16'sd12868, -16'sd12868, 16'sd6434,
                 -16'sd6434, 16'sd6435, -16'sd6435, 16'sd25736, -16'sd25736,
                 16'sd1, -16'sd1, 16'sh5555, 16'shaaaa};
    foreach (directed[i]) begin
      a.angle_x = directed[i];
      a.angle_y = directed[(i + 3) % directed.size()];
      a.angle_z = directed[(i + 7) % directed.size()];
      send_angles(a);
    end
    send_angles('{16'sh8000, 16'sh8000, 16'sh8000});
    send_angles('{16'sh7fff, 16'sh7fff, 16'sh7fff});
    send_angles('{16'sh5555, 16'shaaaa, 16'sh5555});
    send_angles('{16'shaaaa, 16'sh5555, 16'shaaaa});
    send_angles('{16'sd12868, 16'sd12868, 16'sd12868});

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      if (i == 200) hold_off = 1;   // sender keeps offering through it
      a.angle_x = pick_angle();
      a.angle_y = pick_angle();
      a.angle_z = pick_angle();
      send_angles(a);
      if (i % 50 > 10) idle_input(gap_len());
    end
    angle_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    drain = 0;
    while (drain < DRAIN_CYCLES) begin
      @(posedge clk);
      drain++;
    end
    $display("Ran %0d angle beats (directed edges, quadrant limits, random) and checked %0d matrices.",
             sent_count, matrix_count);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d matrices still pending.", pending_count);
    $display("== FAIL ==");
    $finish;
  end
endmodule
`default_nettype wire
